// ===== src/tdp_pkg.sv =====
package tdp_pkg;

  // Width of the candidate field as it crosses the request channel.
  localparam int unsigned CandWidth = 32;

  typedef logic [CandWidth-1:0] candidate_t;

endpackage

// ===== src/tdp_req_if.sv =====
interface tdp_req_if;

  logic                valid;
  logic                ready;
  tdp_pkg::candidate_t candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);

endinterface

// ===== src/tdp_rsp_if.sv =====
interface tdp_rsp_if;

  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);

endinterface

// ===== src/trial_division_prime_test.sv =====
// Zero, one, two and even values are settled straight from the start state;
// other values are divided by each odd trial divisor from 3 upward, one
// bit-serial remainder pass each, until a divisor divides the candidate or
// its square passes it. Throughput: one request at a time; the
// bit-serial remainder loop sets the pace. A finished result waits in an output
// register while the next request is taken. Reset (rst_ni low, asynchronous)
// returns to idle and drops the result valid.
module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tdp_req_if.sink          req_i,
  tdp_rsp_if.source        rsp_o
);

  // Counter for the bits of one remainder pass, and the width of the running
  // square, which may step a little past the largest value before it stops.
  localparam int unsigned CntW = $clog2(VALUE_WIDTH);
  localparam int unsigned SqW  = VALUE_WIDTH + 2;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StBound,
    StDiv,
    StTest,
    StDone
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_prime_q;

  // Datapath registers. The candidate is held in v_q, the trial divisor in
  // d_q, and its square in sq_q. The square is advanced with the identity
  // (d + 2)^2 = d^2 + 4d + 4, so no multiplier is needed.
  logic [VALUE_WIDTH-1:0] v_q;
  logic [VALUE_WIDTH-1:0] d_q;
  logic [SqW-1:0]         sq_q;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] sh_q;
  logic [CntW-1:0]        cnt_q;
  logic                   res_q;

  logic                   req_fire;
  logic                   is_two;
  logic                   trivial;
  logic                   bound_done;
  logic                   rem_zero;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic [VALUE_WIDTH-1:0] rem_d;
  logic                   out_free;

  assign req_i.ready    = (state_q == StIdle);
  assign req_fire       = req_i.valid && req_i.ready;
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.is_prime = out_prime_q;
  assign out_free       = !out_valid_q || rsp_o.ready;

  // Zero, one and every even value settle at once; only two among them is prime.
  assign is_two     = (v_q == VALUE_WIDTH'(2));
  assign trivial    = (v_q < VALUE_WIDTH'(2)) || !v_q[0] || is_two;
  // The search ends once the divisor squared passes the candidate.
  assign bound_done = (sq_q > SqW'(v_q));
  assign rem_zero   = (rem_q == '0);

  // One restoring division step: bring in the next candidate bit from the
  // top and subtract the divisor if it fits. The remainder always stays
  // below the divisor, so the partial value never needs more than one
  // extra bit.
  assign trial = {rem_q, sh_q[VALUE_WIDTH-1]};
  assign diff  = trial - (VALUE_WIDTH + 1)'(d_q);
  assign rem_d = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];

  // Sequencer and registered response.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      out_prime_q <= 1'b0;
    end else begin
      // A finished test loads the output register whenever it is free;
      // otherwise a taken response empties it.
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
        out_prime_q <= res_q;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (req_fire) begin
            state_q <= StStart;
          end
        end
        StStart: begin
          state_q <= trivial ? StDone : StBound;
        end
        StBound: begin
          state_q <= bound_done ? StDone : StDiv;
        end
        StDiv: begin
          if (cnt_q == '0) begin
            state_q <= StTest;
          end
        end
        StTest: begin
          state_q <= rem_zero ? StDone : StBound;
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Datapath. None of it needs a reset: every register is loaded before use.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (req_fire) begin
          // Bits above the datapath width are dropped; a wider datapath
          // zero-extends the candidate.
          v_q <= VALUE_WIDTH'(req_i.candidate);
        end
      end
      StStart: begin
        res_q <= is_two;
        d_q   <= VALUE_WIDTH'(3);
        sq_q  <= SqW'(9);
      end
      StBound: begin
        // No divisor up to the square root leaves the candidate prime.
        res_q <= 1'b1;
        rem_q <= '0;
        sh_q  <= v_q;
        cnt_q <= CntW'(VALUE_WIDTH - 1);
      end
      StDiv: begin
        rem_q <= rem_d;
        sh_q  <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_q <= cnt_q - CntW'(1);
      end
      StTest: begin
        res_q <= 1'b0;
        d_q   <= d_q + VALUE_WIDTH'(2);
        sq_q  <= sq_q + (SqW'(d_q) << 2) + SqW'(4);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/tdp_checker.sv =====
module tdp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic                is_prime_i
);

  // A response that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before it was taken");

  // A stalled response keeps its verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(is_prime_i))
    else $error("response changed while stalled");

  // Once a request is taken, the tester is busy and takes no other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second request taken while a test is running");

  // A new response only appears when a test has just finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("response raised without a finished test");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .is_prime_i  (rsp_o.is_prime)
);
